@@ hw/rtl/fls_pkg.sv @@
package fls_pkg;

  localparam int unsigned GROUP_DEF = 8;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned CNT_W     = 12;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned MAX_DIM   = 4096;

  typedef enum logic [IDX_W-1:0] {
    REG_HEIGHT       = 3'd0,
    REG_WIDTH        = 3'd1,
    REG_CHANNELS     = 3'd2,
    REG_BASE         = 3'd3,
    REG_ROW_STRIDE   = 3'd4,
    REG_GROUP_STRIDE = 3'd5
  } cfg_reg_e;

  // effective configuration: last index of each dimension plus address terms
  typedef struct packed {
    logic [CNT_W-1:0]  last_row;
    logic [CNT_W-1:0]  last_col;
    logic [CNT_W-1:0]  last_ch;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] row_stride;
    logic [ADDR_W-1:0] group_stride;
  } cfg_t;

endpackage

@@ hw/rtl/fls_cfg_regs.sv @@
module fls_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fls_pkg::IDX_W-1:0]       cfg_index_i,
  input  logic [fls_pkg::ADDR_W-1:0]      cfg_data_i,
  output fls_pkg::cfg_t                   cfg_o,
  output fls_pkg::cfg_t                   cfg_next_o
);

  logic [fls_pkg::DIM_W-1:0]  height_q, height_d;
  logic [fls_pkg::DIM_W-1:0]  width_q, width_d;
  logic [fls_pkg::DIM_W-1:0]  chans_q, chans_d;
  logic [fls_pkg::ADDR_W-1:0] base_q, base_d;
  logic [fls_pkg::ADDR_W-1:0] rstride_q, rstride_d;
  logic [fls_pkg::ADDR_W-1:0] gstride_q, gstride_d;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [fls_pkg::CNT_W-1:0] last_idx(input logic [fls_pkg::DIM_W-1:0] dim);
    logic [fls_pkg::CNT_W-1:0] res;
    if (dim == '0) begin
      res = '0;
    end else if (dim > fls_pkg::DIM_W'(fls_pkg::MAX_DIM)) begin
      res = fls_pkg::CNT_W'(fls_pkg::MAX_DIM - 1);
    end else begin
      res = fls_pkg::CNT_W'(dim - fls_pkg::DIM_W'(1));
    end
    return res;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_comb begin
    height_d  = height_q;
    width_d   = width_q;
    chans_d   = chans_q;
    base_d    = base_q;
    rstride_d = rstride_q;
    gstride_d = gstride_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        fls_pkg::REG_HEIGHT:       height_d  = cfg_data_i[fls_pkg::DIM_W-1:0];
        fls_pkg::REG_WIDTH:        width_d   = cfg_data_i[fls_pkg::DIM_W-1:0];
        fls_pkg::REG_CHANNELS:     chans_d   = cfg_data_i[fls_pkg::DIM_W-1:0];
        fls_pkg::REG_BASE:         base_d    = cfg_data_i;
        fls_pkg::REG_ROW_STRIDE:   rstride_d = cfg_data_i;
        fls_pkg::REG_GROUP_STRIDE: gstride_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q  <= fls_pkg::DIM_W'(1);
      width_q   <= fls_pkg::DIM_W'(1);
      chans_q   <= fls_pkg::DIM_W'(1);
      base_q    <= '0;
      rstride_q <= '0;
      gstride_q <= '0;
    end else begin
      height_q  <= height_d;
      width_q   <= width_d;
      chans_q   <= chans_d;
      base_q    <= base_d;
      rstride_q <= rstride_d;
      gstride_q <= gstride_d;
    end
  end

  always_comb begin
    cfg_o.last_row     = last_idx(height_q);
    cfg_o.last_col     = last_idx(width_q);
    cfg_o.last_ch      = last_idx(chans_q);
    cfg_o.base         = base_q;
    cfg_o.row_stride   = rstride_q;
    cfg_o.group_stride = gstride_q;

    cfg_next_o.last_row     = last_idx(height_d);
    cfg_next_o.last_col     = last_idx(width_d);
    cfg_next_o.last_ch      = last_idx(chans_d);
    cfg_next_o.base         = base_d;
    cfg_next_o.row_stride   = rstride_d;
    cfg_next_o.group_stride = gstride_d;
  end

endmodule

@@ hw/rtl/fls_addr_gen.sv @@
module fls_addr_gen #(
  parameter int unsigned GROUP  = fls_pkg::GROUP_DEF,
  parameter int unsigned SLOT_W = $clog2(GROUP)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  fls_pkg::cfg_t               cfg_i,
  input  fls_pkg::cfg_t               cfg_next_i,
  output logic [fls_pkg::ADDR_W-1:0]  first_addr_o,
  output logic [SLOT_W-1:0]           npad_o,
  output logic                        last_elem_o
);

  localparam int unsigned CW    = fls_pkg::CNT_W;
  localparam int unsigned AW    = fls_pkg::ADDR_W;
  localparam int unsigned GRP_W = $clog2((fls_pkg::MAX_DIM - 1) / GROUP + 1);

  logic [CW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic [CW-1:0]     ch_q, ch_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [GRP_W-1:0]  grp_q, grp_d;
  logic [AW-1:0]     row_off_q, grp_off_q, pix_off_q;
  logic [CW+AW-1:0]  row_prod;
  logic [GRP_W+AW-1:0] grp_prod;
  logic [AW-1:0]     pix_off_d;
  logic              last_ch, last_col, last_row;

  assign last_ch  = ch_q >= cfg_i.last_ch;
  assign last_col = col_q >= cfg_i.last_col;
  assign last_row = row_q >= cfg_i.last_row;

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    ch_d   = ch_q;
    slot_d = slot_q;
    grp_d  = grp_q;
    if (adv_i) begin
      if (last_ch) begin
        ch_d   = '0;
        slot_d = '0;
        grp_d  = '0;
        if (last_col) begin
          col_d = '0;
          row_d = last_row ? '0 : row_q + CW'(1);
        end else begin
          col_d = col_q + CW'(1);
        end
      end else begin
        ch_d = ch_q + CW'(1);
        if (slot_q == SLOT_W'(GROUP - 1)) begin
          slot_d = '0;
          grp_d  = grp_q + GRP_W'(1);
        end else begin
          slot_d = slot_q + SLOT_W'(1);
        end
      end
    end
  end

  // offsets for the coming item, computed from the next counter values and registered together with the counters
  assign row_prod  = row_d * cfg_next_i.row_stride;
  assign grp_prod  = grp_d * cfg_next_i.group_stride;
  assign pix_off_d = (AW'(col_d) * AW'(GROUP) + AW'(slot_d)) << 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      ch_q      <= '0;
      slot_q    <= '0;
      grp_q     <= '0;
      row_off_q <= '0;
      grp_off_q <= '0;
      pix_off_q <= '0;
    end else begin
      row_q     <= row_d;
      col_q     <= col_d;
      ch_q      <= ch_d;
      slot_q    <= slot_d;
      grp_q     <= grp_d;
      row_off_q <= row_prod[AW-1:0];
      grp_off_q <= grp_prod[AW-1:0];
      pix_off_q <= pix_off_d;
    end
  end

  assign first_addr_o = cfg_i.base + grp_off_q + row_off_q + pix_off_q;
  assign npad_o       = last_ch ? SLOT_W'(GROUP - 1) - slot_q : '0;
  assign last_elem_o  = last_ch & last_col & last_row;

endmodule

@@ hw/rtl/fls_write_seq.sv @@
module fls_write_seq #(
  parameter int unsigned GROUP  = fls_pkg::GROUP_DEF,
  parameter int unsigned SLOT_W = $clog2(GROUP)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  output logic                               accept_o,
  input  logic signed [fls_pkg::DATA_W-1:0]  element_value_i,
  input  logic [fls_pkg::ADDR_W-1:0]         first_addr_i,
  input  logic [SLOT_W-1:0]                  npad_i,
  input  logic                               last_elem_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [fls_pkg::ADDR_W-1:0]         write_address_o,
  output logic signed [fls_pkg::DATA_W-1:0]  write_value_o,
  output logic                               is_padding_o,
  output logic                               run_last_o,
  output logic                               tensor_done_o
);

  localparam int unsigned AW = fls_pkg::ADDR_W;

  logic                              valid_q, valid_d;
  logic [AW-1:0]                     addr_q, addr_d;
  logic signed [fls_pkg::DATA_W-1:0] value_q, value_d;
  logic                              pad_q, pad_d;
  logic [SLOT_W-1:0]                 rem_q, rem_d;
  logic                              done_q, done_d;
  logic                              out_fire, final_beat;

  assign out_fire   = valid_q & ~out_stall_i;
  assign final_beat = rem_q == '0;
  assign in_stall_o = valid_q & ~(out_fire & final_beat);
  assign accept_o   = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    addr_d  = addr_q;
    value_d = value_q;
    pad_d   = pad_q;
    rem_d   = rem_q;
    done_d  = done_q;
    if (accept_o) begin
      valid_d = 1'b1;
      addr_d  = first_addr_i;
      value_d = element_value_i;
      pad_d   = 1'b0;
      rem_d   = npad_i;
      done_d  = last_elem_i;
    end else if (out_fire) begin
      if (final_beat) begin
        valid_d = 1'b0;
      end else begin
        // next padding slot of the same group
        addr_d  = addr_q + AW'(2);
        value_d = '0;
        pad_d   = 1'b1;
        rem_d   = rem_q - SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    value_q <= value_d;
    pad_q   <= pad_d;
    rem_q   <= rem_d;
    done_q  <= done_d;
  end

  assign out_valid_o     = valid_q;
  assign write_address_o = addr_q;
  assign write_value_o   = value_q;
  assign is_padding_o    = pad_q;
  assign run_last_o      = final_beat;
  assign tensor_done_o   = final_beat & done_q;

  a_pad_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && rem_q != '0) |-> in_stall_o)
    else $error("input taken while padding beats remain");

  a_pad_addr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !final_beat) |=> (valid_q && pad_q && addr_q == $past(addr_q) + AW'(2)))
    else $error("padding beat address not next slot");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && pad_q) |-> (value_q == '0))
    else $error("padding beat carries nonzero value");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_o |=> (valid_q && !pad_q))
    else $error("accepted element not presented as data beat");

endmodule

@@ hw/rtl/feature_layout_scatter.sv @@
// feature_layout_scatter: scatters 16-bit tensor elements, streamed in row,
// column, channel order, into a channel-grouped memory layout.
// input channel: in_valid_i / in_stall_o with element_value_i.
// output channel: out_valid_o / out_stall_i carrying one memory write per
// beat (write_address_o, write_value_o, is_padding_o, run_last_o,
// tensor_done_o).
// config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// always ready, write only while no element is in flight.
// the first write of an element is registered and appears in the cycle after accept.
// throughput: one element per cycle while out_stall_i is low; an element that ends
// a pixel whose last channel sits in slot s of its group occupies GROUP - s output
// beats, set by the single output register that emits the zero padding writes.
// reset: dimensions go to 1, base and strides to 0, row, column and channel
// counters to 0, output empty.
// a stalled output holds its beat; the input is stalled while the output
// register is full and not emitting its final beat.
module feature_layout_scatter #(
  parameter int unsigned GROUP = fls_pkg::GROUP_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [fls_pkg::DATA_W-1:0]  element_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [fls_pkg::ADDR_W-1:0]         write_address_o,
  output logic signed [fls_pkg::DATA_W-1:0]  write_value_o,
  output logic                               is_padding_o,
  output logic                               run_last_o,
  output logic                               tensor_done_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fls_pkg::IDX_W-1:0]          cfg_index_i,
  input  logic [fls_pkg::ADDR_W-1:0]         cfg_data_i
);

  localparam int unsigned SLOT_W = $clog2(GROUP);

  fls_pkg::cfg_t               cfg, cfg_next;
  logic                        accept;
  logic [fls_pkg::ADDR_W-1:0]  first_addr;
  logic [SLOT_W-1:0]           npad;
  logic                        last_elem;

  fls_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .cfg_next_o  (cfg_next)
  );

  fls_addr_gen #(
    .GROUP  (GROUP),
    .SLOT_W (SLOT_W)
  ) u_addr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (accept),
    .cfg_i        (cfg),
    .cfg_next_i   (cfg_next),
    .first_addr_o (first_addr),
    .npad_o       (npad),
    .last_elem_o  (last_elem)
  );

  fls_write_seq #(
    .GROUP  (GROUP),
    .SLOT_W (SLOT_W)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .accept_o        (accept),
    .element_value_i (element_value_i),
    .first_addr_i    (first_addr),
    .npad_i          (npad),
    .last_elem_i     (last_elem),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .write_address_o (write_address_o),
    .write_value_o   (write_value_o),
    .is_padding_o    (is_padding_o),
    .run_last_o      (run_last_o),
    .tensor_done_o   (tensor_done_o)
  );

endmodule
